@@ hw/rtl/mbc3_pkg.sv @@
// Shared constants for the MBC3-style bank controller with real-time clock.
// Holds memory geometry, operation codes, register indexes and clock masks.
// No dependencies.
`timescale 1ns / 1ps

package mbc3_pkg;

  // Cartridge geometry
  localparam int RAM_BANK_COUNT = 4;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BITS  = 8;
  localparam int ROM_BANK_BYTES = 16384;

  localparam int RAM_DEPTH  = RAM_BANK_COUNT * RAM_BANK_BYTES;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int RAM_OFF_W  = $clog2(RAM_BANK_BYTES);
  localparam int RAM_BANK_W = (RAM_BANK_COUNT > 1) ? $clog2(RAM_BANK_COUNT) : 1;
  localparam int ROM_OFF_W  = $clog2(ROM_BANK_BYTES);
  localparam int ROM_ADDR_W = 22;

  localparam logic [7:0] ROM_BANK_FIELD = 8'((1 << ROM_BANK_BITS) - 1);

  // Operation codes of an input transaction
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROM_BANK_MASK    = 2'd0;
  localparam logic [1:0] CFG_RAM_SIZE_CODE    = 2'd1;
  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd2;

  // RAM size codes
  localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
  localparam logic [1:0] RAM_SIZE_ONE  = 2'd1;

  // Bank / clock register select codes
  localparam logic [3:0] SEL_RAM_LIMIT = 4'h4;
  localparam logic [3:0] SEL_SEC       = 4'h8;
  localparam logic [3:0] SEL_MIN       = 4'h9;
  localparam logic [3:0] SEL_HOUR      = 4'hA;
  localparam logic [3:0] SEL_DAYL      = 4'hB;
  localparam logic [3:0] SEL_DAYH      = 4'hC;

  // Bus address map
  localparam logic [15:0] ADDR_BANK_REG  = 16'h2000;
  localparam logic [15:0] ADDR_ROM_SEL   = 16'h4000;
  localparam logic [15:0] ADDR_RAM_SEL   = 16'h6000;
  localparam logic [15:0] ADDR_LATCH     = 16'h8000;
  localparam logic [15:0] ADDR_RAM_LO    = 16'hA000;
  localparam logic [15:0] ADDR_RAM_HI    = 16'hC000;

  // Clock masks and limits
  localparam logic [3:0] RAM_EN_KEY  = 4'hA;
  localparam logic [7:0] SEC_MASK    = 8'h3F;
  localparam logic [7:0] MIN_MASK    = 8'h3F;
  localparam logic [7:0] HOUR_MASK   = 8'h1F;
  localparam logic [7:0] DAYH_MASK   = 8'hC1;
  localparam logic [7:0] DAYH_CARRY  = 8'h80;
  localparam logic [5:0] SEC_LIMIT   = 6'd60;
  localparam logic [5:0] MIN_LIMIT   = 6'd60;
  localparam logic [4:0] HOUR_LIMIT  = 5'd24;
  localparam logic [9:0] DAY_LIMIT   = 10'd512;
  localparam int         DAYH_HALT   = 6;

  localparam logic [7:0] UNMAPPED    = 8'hFF;

endpackage

@@ hw/rtl/mbc3_bank_mapper_with_rtc.sv @@
// Top level of the MBC3-style bank controller with real-time clock.
// Depends on mbc3_pkg for geometry, codes and clock constants.
// A read's result is registered in the read stage, then in the output register, before it is offered.
// One transaction per cycle while in_ready is high; a held read stage or the clearing pass holds it low.
// A result waits in the output register while the next transaction is accepted.
// Reset: synchronous, active low; clears control and clock registers, then runs a
// clearing pass over all RAM_DEPTH (32768) bytes of the RAM with in_ready low.
`timescale 1ns / 1ps

module mbc3_bank_mapper_with_rtc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_from_rom,
  output logic [21:0] out_rom_address,
  output logic [7:0]  out_read_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  // Configuration registers
  logic [7:0]  rom_bank_mask_r;
  logic [1:0]  ram_size_code_r;
  logic [23:0] tps_r;

  // Controller and clock state
  logic        ram_en_r, ram_en_nxt;
  logic [7:0]  rom_bank_r, rom_bank_nxt;
  logic [3:0]  ram_sel_r, ram_sel_nxt;
  logic [7:0]  latch_byte_r, latch_byte_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [7:0]  dayl_r, dayl_nxt;
  logic [7:0]  dayh_r, dayh_nxt;
  logic [23:0] tick_r, tick_nxt;
  logic [7:0]  latched_r [5];
  logic [7:0]  latched_nxt [5];

  // RAM and its clearing pass
  logic [7:0]                 mem [mbc3_pkg::RAM_DEPTH];
  logic [7:0]                 ram_q_r;
  logic                       clearing_r;
  logic [mbc3_pkg::RAM_AW-1:0] clr_addr_r;
  logic                       mem_we;
  logic [mbc3_pkg::RAM_AW-1:0] mem_waddr;
  logic [7:0]                 mem_wdata;

  // Pipeline registers
  logic        s1_valid_r;
  logic        s1_from_rom_r;
  logic [21:0] s1_rom_addr_r;
  logic [7:0]  s1_data_r;
  logic        s1_use_ram_r;
  logic        out_valid_r;
  logic        out_from_rom_r;
  logic [21:0] out_rom_addr_r;
  logic [7:0]  out_data_r;

  // Decode
  logic        acc;
  logic        s1_adv;
  logic        is_rd, is_wr, is_tk;
  logic        in_win;
  logic        sel_is_ram, sel_is_rtc;
  logic [2:0]  nbanks;
  logic [2:0]  sel_lo;
  logic [2:0]  bank_wrap;
  logic [mbc3_pkg::RAM_BANK_W-1:0] bank;
  logic [mbc3_pkg::RAM_AW-1:0]     ram_idx;
  logic        ram_access;
  logic        ram_re;
  logic        ram_wr;
  logic [7:0]  rtc_byte;

  // Read result before the RAM data joins
  logic        rd_from_rom;
  logic [21:0] rd_rom_addr;
  logic [7:0]  rd_data;
  logic        rd_use_ram;

  // Tick arithmetic
  logic [23:0] tick_inc;
  logic [5:0]  sec_inc, min_inc;
  logic [4:0]  hour_inc;
  logic [9:0]  day_inc;

  // Handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign acc      = in_valid && in_ready;

  assign is_rd = (in_mode == mbc3_pkg::MODE_READ);
  assign is_wr = (in_mode == mbc3_pkg::MODE_WRITE);
  assign is_tk = (in_mode == mbc3_pkg::MODE_TICK);

  assign in_win     = (in_address >= mbc3_pkg::ADDR_RAM_LO) &&
                      (in_address <  mbc3_pkg::ADDR_RAM_HI);
  assign sel_is_ram = (ram_sel_r < mbc3_pkg::SEL_RAM_LIMIT);
  assign sel_is_rtc = (ram_sel_r >= mbc3_pkg::SEL_SEC) && (ram_sel_r <= mbc3_pkg::SEL_DAYH);

  // Banks present: the smaller of the size code's count and the banks fitted
  always_comb begin
    case (ram_size_code_r)
      mbc3_pkg::RAM_SIZE_NONE: nbanks = 3'd0;
      mbc3_pkg::RAM_SIZE_ONE:  nbanks = 3'd1;
      default:                 nbanks = 3'd4;
    endcase
    if (nbanks > 3'(mbc3_pkg::RAM_BANK_COUNT)) begin
      nbanks = 3'(mbc3_pkg::RAM_BANK_COUNT);
    end
  end

  // Wrap the bank number to the banks present; select is below four here
  assign sel_lo = {1'b0, ram_sel_r[1:0]};
  always_comb begin
    if (nbanks <= 3'd1) begin
      bank_wrap = 3'd0;
    end else if (sel_lo >= nbanks) begin
      bank_wrap = sel_lo - nbanks;
    end else begin
      bank_wrap = sel_lo;
    end
  end
  assign bank    = mbc3_pkg::RAM_BANK_W'(bank_wrap);
  assign ram_idx = mbc3_pkg::RAM_AW'({bank, in_address[mbc3_pkg::RAM_OFF_W-1:0]});

  assign ram_access = acc && in_win && ram_en_r && sel_is_ram && (nbanks != 3'd0);
  assign ram_re     = ram_access && is_rd;
  assign ram_wr     = ram_access && is_wr;

  // Latched clock byte for the current select
  always_comb begin
    case (ram_sel_r)
      mbc3_pkg::SEL_SEC:  rtc_byte = latched_r[0];
      mbc3_pkg::SEL_MIN:  rtc_byte = latched_r[1];
      mbc3_pkg::SEL_HOUR: rtc_byte = latched_r[2];
      mbc3_pkg::SEL_DAYL: rtc_byte = latched_r[3];
      mbc3_pkg::SEL_DAYH: rtc_byte = latched_r[4];
      default:            rtc_byte = mbc3_pkg::UNMAPPED;
    endcase
  end

  // Read result: ROM address, clock byte or RAM data to follow
  always_comb begin
    rd_from_rom = 1'b0;
    rd_rom_addr = '0;
    rd_data     = mbc3_pkg::UNMAPPED;
    rd_use_ram  = 1'b0;
    if (in_address < mbc3_pkg::ADDR_LATCH) begin
      rd_from_rom = 1'b1;
      rd_data     = 8'h00;
      if (in_address >= mbc3_pkg::ADDR_ROM_SEL) begin
        rd_rom_addr = 22'({rom_bank_r, in_address[mbc3_pkg::ROM_OFF_W-1:0]});
      end else begin
        rd_rom_addr = 22'(in_address);
      end
    end else if (in_win && ram_en_r) begin
      if (sel_is_ram) begin
        rd_use_ram = (nbanks != 3'd0);
      end else if (sel_is_rtc) begin
        rd_data = rtc_byte;
      end
    end
  end

  // Tick increments
  assign tick_inc = tick_r + 24'd1;
  assign sec_inc  = sec_r + 6'd1;
  assign min_inc  = min_r + 6'd1;
  assign hour_inc = hour_r + 5'd1;
  assign day_inc  = {1'b0, dayh_r[0], dayl_r} + 10'd1;

  // Next state of controller and clock registers
  always_comb begin
    ram_en_nxt     = ram_en_r;
    rom_bank_nxt   = rom_bank_r;
    ram_sel_nxt    = ram_sel_r;
    latch_byte_nxt = latch_byte_r;
    sec_nxt        = sec_r;
    min_nxt        = min_r;
    hour_nxt       = hour_r;
    dayl_nxt       = dayl_r;
    dayh_nxt       = dayh_r;
    tick_nxt       = tick_r;
    for (int i = 0; i < 5; i++) begin
      latched_nxt[i] = latched_r[i];
    end

    if (acc && is_tk && !dayh_r[mbc3_pkg::DAYH_HALT]) begin
      // Advance the clock, carrying only on the exact limits
      if (tick_inc < tps_r) begin
        tick_nxt = tick_inc;
      end else begin
        tick_nxt = '0;
        if (sec_inc != mbc3_pkg::SEC_LIMIT) begin
          sec_nxt = sec_inc;
        end else begin
          sec_nxt = '0;
          if (min_inc != mbc3_pkg::MIN_LIMIT) begin
            min_nxt = min_inc;
          end else begin
            min_nxt = '0;
            if (hour_inc != mbc3_pkg::HOUR_LIMIT) begin
              hour_nxt = hour_inc;
            end else begin
              hour_nxt = '0;
              dayl_nxt = day_inc[7:0];
              dayh_nxt = {dayh_r[7:1], day_inc[8]};
              if (day_inc == mbc3_pkg::DAY_LIMIT) begin
                dayl_nxt = 8'h00;
                dayh_nxt = {dayh_r[7:1], 1'b0} | mbc3_pkg::DAYH_CARRY;
              end
            end
          end
        end
      end
    end else if (acc && is_wr) begin
      if (in_address < mbc3_pkg::ADDR_BANK_REG) begin
        ram_en_nxt = (in_write_value[3:0] == mbc3_pkg::RAM_EN_KEY);
      end else if (in_address < mbc3_pkg::ADDR_ROM_SEL) begin
        // Zero selects bank one; other values go through the mask
        if (in_write_value == 8'h00) begin
          rom_bank_nxt = 8'h01;
        end else begin
          rom_bank_nxt = in_write_value & rom_bank_mask_r & mbc3_pkg::ROM_BANK_FIELD;
        end
      end else if (in_address < mbc3_pkg::ADDR_RAM_SEL) begin
        // Drop select values that name neither a bank nor a clock register
        if (in_write_value < 8'(mbc3_pkg::SEL_RAM_LIMIT) ||
            (in_write_value >= 8'(mbc3_pkg::SEL_SEC) &&
             in_write_value <= 8'(mbc3_pkg::SEL_DAYH))) begin
          ram_sel_nxt = in_write_value[3:0];
        end
      end else if (in_address < mbc3_pkg::ADDR_LATCH) begin
        // Latch the live clock on a zero-to-one change
        if (in_write_value == 8'h01 && latch_byte_r == 8'h00) begin
          latched_nxt[0] = {2'b00, sec_r};
          latched_nxt[1] = {2'b00, min_r};
          latched_nxt[2] = {3'b000, hour_r};
          latched_nxt[3] = dayl_r;
          latched_nxt[4] = dayh_r;
        end
        latch_byte_nxt = in_write_value;
      end else if (in_win && ram_en_r) begin
        // Clock register writes go to both live and latched copies
        case (ram_sel_r)
          mbc3_pkg::SEL_SEC: begin
            sec_nxt        = in_write_value[5:0];
            latched_nxt[0] = in_write_value & mbc3_pkg::SEC_MASK;
            tick_nxt       = '0;
          end
          mbc3_pkg::SEL_MIN: begin
            min_nxt        = in_write_value[5:0];
            latched_nxt[1] = in_write_value & mbc3_pkg::MIN_MASK;
          end
          mbc3_pkg::SEL_HOUR: begin
            hour_nxt       = in_write_value[4:0];
            latched_nxt[2] = in_write_value & mbc3_pkg::HOUR_MASK;
          end
          mbc3_pkg::SEL_DAYL: begin
            dayl_nxt       = in_write_value;
            latched_nxt[3] = in_write_value;
          end
          mbc3_pkg::SEL_DAYH: begin
            dayh_nxt       = in_write_value & mbc3_pkg::DAYH_MASK;
            latched_nxt[4] = in_write_value & mbc3_pkg::DAYH_MASK;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_mask_r <= 8'h01;
      ram_size_code_r <= 2'd2;
      tps_r           <= 24'd4194304;
    end else if (cfg_we) begin
      case (cfg_index)
        mbc3_pkg::CFG_ROM_BANK_MASK:    rom_bank_mask_r <= cfg_wdata[7:0];
        mbc3_pkg::CFG_RAM_SIZE_CODE:    ram_size_code_r <= cfg_wdata[1:0];
        mbc3_pkg::CFG_TICKS_PER_SECOND: tps_r           <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Controller and clock registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_en_r     <= 1'b0;
      rom_bank_r   <= 8'h01;
      ram_sel_r    <= '0;
      latch_byte_r <= '0;
      sec_r        <= '0;
      min_r        <= '0;
      hour_r       <= '0;
      dayl_r       <= '0;
      dayh_r       <= '0;
      tick_r       <= '0;
      for (int i = 0; i < 5; i++) begin
        latched_r[i] <= '0;
      end
    end else begin
      ram_en_r     <= ram_en_nxt;
      rom_bank_r   <= rom_bank_nxt;
      ram_sel_r    <= ram_sel_nxt;
      latch_byte_r <= latch_byte_nxt;
      sec_r        <= sec_nxt;
      min_r        <= min_nxt;
      hour_r       <= hour_nxt;
      dayl_r       <= dayl_nxt;
      dayh_r       <= dayh_nxt;
      tick_r       <= tick_nxt;
      for (int i = 0; i < 5; i++) begin
        latched_r[i] <= latched_nxt[i];
      end
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == mbc3_pkg::RAM_AW'(mbc3_pkg::RAM_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // RAM: one write port shared with the clearing pass, registered read
  assign mem_we    = clearing_r || ram_wr;
  assign mem_waddr = clearing_r ? clr_addr_r : ram_idx;
  assign mem_wdata = clearing_r ? 8'h00 : in_write_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ram_re) begin
      ram_q_r <= mem[ram_idx];
    end
  end

  // Read stage: hold the result while the RAM data arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc && is_rd) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_rd) begin
      s1_from_rom_r <= rd_from_rom;
      s1_rom_addr_r <= rd_rom_addr;
      s1_data_r     <= rd_data;
      s1_use_ram_r  <= rd_use_ram;
    end
  end

  // Output register: merge RAM data and offer the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_from_rom_r <= s1_from_rom_r;
      out_rom_addr_r <= s1_rom_addr_r;
      out_data_r     <= s1_use_ram_r ? ram_q_r : s1_data_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_from_rom    = out_from_rom_r;
  assign out_rom_address = out_rom_addr_r;
  assign out_read_data   = out_data_r;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the MBC3-style bank controller with real-time clock.
// Needs mbc3_pkg and mbc3_bank_mapper_with_rtc; predicts every read result in-house.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] addr;
    logic [7:0]  wval;
  } bus_txn_t;

  typedef struct packed {
    logic        from_rom;
    logic [21:0] rom_addr;
    logic [7:0]  data;
  } rd_result_t;

  // Back-pressure styles applied part way through a phase
  localparam int PRESS_NONE     = 0;
  localparam int PRESS_RX_STALL = 1;
  localparam int PRESS_TX_PAUSE = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = mbc3_pkg::MODE_READ;
  logic [15:0] in_address = 16'h0000;
  logic [7:0]  in_write_value = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_from_rom;
  logic [21:0] out_rom_address;
  logic [7:0]  out_read_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = mbc3_pkg::CFG_ROM_BANK_MASK;
  logic [23:0] cfg_wdata = 24'h0;

  mbc3_bank_mapper_with_rtc DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_address      (in_address),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_from_rom    (out_from_rom),
    .out_rom_address (out_rom_address),
    .out_read_data   (out_read_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus and expectation stores
  bus_txn_t   bus_txn_q[$];
  rd_result_t read_results_q[$];
  bus_txn_t   next_txn;
  rd_result_t pred_res;
  rd_result_t want_res;
  logic       in_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         send_hold = 1'b0;
  int         rx_stall_left = 0;
  int         n_errors = 0;
  int         n_queued = 0;
  int         n_accepted = 0;
  int         n_checked = 0;
  int         n_ticks = 0;
  int         n_settings = 0;

  // Mirror of the controller state
  logic [7:0]  m_rom_mask = 8'h01;
  logic [1:0]  m_ram_code = 2'd2;
  logic [23:0] m_tps = 24'd4194304;
  logic [7:0]  ram_img [0:mbc3_pkg::RAM_DEPTH-1];
  logic        ram_on = 1'b0;
  logic [7:0]  rom_sel = 8'h01;
  logic [3:0]  ram_sel = 4'h0;
  logic [7:0]  latch_prev = 8'h00;
  logic [5:0]  rtc_sec = 6'd0;
  logic [5:0]  rtc_min = 6'd0;
  logic [4:0]  rtc_hr = 5'd0;
  logic [7:0]  rtc_dl = 8'h00;
  logic [7:0]  rtc_dh = 8'h00;
  logic [7:0]  rtc_latch [0:4] = '{default: 8'h00};
  logic [23:0] tick_cnt = 24'd0;

  // Values just short of a carry, per clock register in select order
  logic [7:0]  near_limit [0:4] = '{8'd59, 8'd59, 8'd23, 8'hFF, 8'h01};

  function automatic int unsigned banks_fitted();
    int unsigned nb;
    nb = (m_ram_code == mbc3_pkg::RAM_SIZE_NONE) ? 0 :
         (m_ram_code == mbc3_pkg::RAM_SIZE_ONE) ? 1 : 4;
    if (nb > mbc3_pkg::RAM_BANK_COUNT) nb = mbc3_pkg::RAM_BANK_COUNT;
    return nb;
  endfunction

  function automatic logic [mbc3_pkg::RAM_AW-1:0] ram_slot(input logic [15:0] a,
                                                           input int unsigned nb);
    return mbc3_pkg::RAM_AW'((ram_sel % nb) * mbc3_pkg::RAM_BANK_BYTES +
                             a[mbc3_pkg::RAM_OFF_W-1:0]);
  endfunction

  // Apply one transaction to the mirror; return 1 when it yields a read result
  function automatic bit predict_access(input bus_txn_t t, output rd_result_t r);
    int unsigned nb;
    logic [9:0]  days;
    r = '0;
    nb = banks_fitted();
    case (t.mode)
      mbc3_pkg::MODE_WRITE: begin
        // ADDR_* constants mark the upper end of each register window
        if (t.addr < mbc3_pkg::ADDR_BANK_REG) begin
          ram_on = (t.wval[3:0] == mbc3_pkg::RAM_EN_KEY);
        end else if (t.addr < mbc3_pkg::ADDR_ROM_SEL) begin
          rom_sel = (t.wval != 8'h00) ?
                    (t.wval & m_rom_mask & mbc3_pkg::ROM_BANK_FIELD) : 8'h01;
        end else if (t.addr < mbc3_pkg::ADDR_RAM_SEL) begin
          if (t.wval < mbc3_pkg::SEL_RAM_LIMIT ||
              (t.wval >= mbc3_pkg::SEL_SEC && t.wval <= mbc3_pkg::SEL_DAYH))
            ram_sel = t.wval[3:0];
        end else if (t.addr < mbc3_pkg::ADDR_LATCH) begin
          if (t.wval == 8'h01 && latch_prev == 8'h00) begin
            rtc_latch[0] = 8'(rtc_sec);
            rtc_latch[1] = 8'(rtc_min);
            rtc_latch[2] = 8'(rtc_hr);
            rtc_latch[3] = rtc_dl;
            rtc_latch[4] = rtc_dh;
          end
          latch_prev = t.wval;
        end else if (t.addr >= mbc3_pkg::ADDR_RAM_LO && t.addr < mbc3_pkg::ADDR_RAM_HI &&
                     ram_on) begin
          if (ram_sel < mbc3_pkg::SEL_RAM_LIMIT) begin
            if (nb > 0) ram_img[ram_slot(t.addr, nb)] = t.wval;
          end else begin
            // Clock writes land in both the live and the latched copy
            case (ram_sel)
              mbc3_pkg::SEL_SEC: begin
                rtc_sec = 6'(t.wval & mbc3_pkg::SEC_MASK);
                rtc_latch[0] = 8'(rtc_sec);
                tick_cnt = 24'd0;
              end
              mbc3_pkg::SEL_MIN: begin
                rtc_min = 6'(t.wval & mbc3_pkg::MIN_MASK);
                rtc_latch[1] = 8'(rtc_min);
              end
              mbc3_pkg::SEL_HOUR: begin
                rtc_hr = 5'(t.wval & mbc3_pkg::HOUR_MASK);
                rtc_latch[2] = 8'(rtc_hr);
              end
              mbc3_pkg::SEL_DAYL: begin
                rtc_dl = t.wval;
                rtc_latch[3] = t.wval;
              end
              mbc3_pkg::SEL_DAYH: begin
                rtc_dh = t.wval & mbc3_pkg::DAYH_MASK;
                rtc_latch[4] = rtc_dh;
              end
              default: ;
            endcase
          end
        end
        return 1'b0;
      end
      mbc3_pkg::MODE_TICK: begin
        // Advance the clock chain unless halted; only exact limits carry
        if (!rtc_dh[mbc3_pkg::DAYH_HALT]) begin
          tick_cnt = tick_cnt + 24'd1;
          if (tick_cnt >= m_tps) begin
            tick_cnt = 24'd0;
            rtc_sec = rtc_sec + 6'd1;
            if (rtc_sec == mbc3_pkg::SEC_LIMIT) begin
              rtc_sec = 6'd0;
              rtc_min = rtc_min + 6'd1;
              if (rtc_min == mbc3_pkg::MIN_LIMIT) begin
                rtc_min = 6'd0;
                rtc_hr = rtc_hr + 5'd1;
                if (rtc_hr == mbc3_pkg::HOUR_LIMIT) begin
                  rtc_hr = 5'd0;
                  days = {1'b0, rtc_dh[0], rtc_dl} + 10'd1;
                  if (days == mbc3_pkg::DAY_LIMIT) begin
                    days = 10'd0;
                    rtc_dh = rtc_dh | mbc3_pkg::DAYH_CARRY;
                  end
                  rtc_dl = days[7:0];
                  rtc_dh = {rtc_dh[7:1], days[8]};
                end
              end
            end
          end
        end
        return 1'b0;
      end
      mbc3_pkg::MODE_READ: begin
        if (t.addr < mbc3_pkg::ADDR_LATCH) begin
          // 0x4000 also opens the switchable ROM window
          r.from_rom = 1'b1;
          r.rom_addr = (t.addr >= mbc3_pkg::ADDR_ROM_SEL) ?
                       {rom_sel, t.addr[mbc3_pkg::ROM_OFF_W-1:0]} :
                       mbc3_pkg::ROM_ADDR_W'(t.addr);
        end else begin
          r.data = mbc3_pkg::UNMAPPED;
          if (t.addr >= mbc3_pkg::ADDR_RAM_LO && t.addr < mbc3_pkg::ADDR_RAM_HI &&
              ram_on) begin
            if (ram_sel < mbc3_pkg::SEL_RAM_LIMIT) begin
              if (nb > 0) r.data = ram_img[ram_slot(t.addr, nb)];
            end else if (ram_sel >= mbc3_pkg::SEL_SEC && ram_sel <= mbc3_pkg::SEL_DAYH) begin
              r.data = rtc_latch[ram_sel - mbc3_pkg::SEL_SEC];
            end
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Offer queued transactions, holding each until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (bus_txn_q.size() != 0 && !send_hold &&
                 $urandom_range(99) >= send_idle_pct) begin
      next_txn = bus_txn_q.pop_front();
      in_valid       <= 1'b1;
      in_mode        <= next_txn.mode;
      in_address     <= next_txn.addr;
      in_write_value <= next_txn.wval;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Drive result back-pressure; a requested stall is counted down here
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on each accepted transaction and check each accepted result
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      n_accepted++;
      if (in_mode == mbc3_pkg::MODE_TICK) n_ticks++;
      if (predict_access('{mode: in_mode, addr: in_address, wval: in_write_value}, pred_res))
        read_results_q.push_back(pred_res);
    end
    if (rst_n && out_valid && out_ready) begin
      if (read_results_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'(out_read_data), 32'h0);
      end else begin
        want_res = read_results_q.pop_front();
        n_checked++;
        if (out_from_rom !== want_res.from_rom)
          report_mismatch("from_rom", 32'(out_from_rom), 32'(want_res.from_rom));
        if (out_rom_address !== want_res.rom_addr)
          report_mismatch("rom_address", 32'(out_rom_address), 32'(want_res.rom_addr));
        if (out_read_data !== want_res.data)
          report_mismatch("read_data", 32'(out_read_data), 32'(want_res.data));
      end
    end
  end

  task automatic next_cycle();
    @(posedge clk);
    #1;
  endtask

  // Wait until all traffic has drained, then allow for in-flight writes and ticks
  task automatic drain();
    do next_cycle();
    while (bus_txn_q.size() != 0 || in_valid || read_results_q.size() != 0);
    repeat (4) next_cycle();
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mbc3_pkg::CFG_ROM_BANK_MASK:    m_rom_mask = val[7:0];
      mbc3_pkg::CFG_RAM_SIZE_CODE:    m_ram_code = val[1:0];
      mbc3_pkg::CFG_TICKS_PER_SECOND: m_tps = val;
      default: ;
    endcase
  endtask

  task automatic push_txn(input logic [1:0] m, input logic [15:0] a, input logic [7:0] v);
    bus_txn_q.push_back('{mode: m, addr: a, wval: v});
    n_queued++;
  endtask

  // Queue one short, mostly well-formed access sequence
  task automatic queue_random_burst();
    int unsigned pick;
    int unsigned k;
    int unsigned n;
    logic [7:0]  v;
    logic [15:0] off;
    pick = $urandom_range(99);
    if (pick < 15) begin
      push_txn(mbc3_pkg::MODE_READ, 16'($urandom_range(16'h7FFF)), 8'($urandom));
    end else if (pick < 22) begin
      v = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
      push_txn(mbc3_pkg::MODE_WRITE,
               16'(mbc3_pkg::ADDR_BANK_REG + $urandom_range(16'h1FFF)), v);
    end else if (pick < 28) begin
      v = ($urandom_range(3) != 0) ? {4'($urandom), mbc3_pkg::RAM_EN_KEY} : 8'($urandom);
      push_txn(mbc3_pkg::MODE_WRITE, 16'($urandom_range(16'h1FFF)), v);
    end else if (pick < 35) begin
      k = $urandom_range(8);
      v = ($urandom_range(9) < 7) ? 8'((k < 4) ? k : k + 4) : 8'($urandom);
      push_txn(mbc3_pkg::MODE_WRITE,
               16'(mbc3_pkg::ADDR_ROM_SEL + $urandom_range(16'h1FFF)), v);
    end else if (pick < 55) begin
      // RAM data: favour a few offsets so that reads hit earlier writes
      if ($urandom_range(9) < 3)
        push_txn(mbc3_pkg::MODE_WRITE, 16'($urandom_range(16'h1FFF)),
                 {4'($urandom), mbc3_pkg::RAM_EN_KEY});
      off = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom_range(16'h1FFF));
      if ($urandom_range(1))
        push_txn(mbc3_pkg::MODE_WRITE, mbc3_pkg::ADDR_RAM_LO + off, 8'($urandom));
      else
        push_txn(mbc3_pkg::MODE_READ, mbc3_pkg::ADDR_RAM_LO + off, 8'($urandom));
    end else if (pick < 62) begin
      v = ($urandom_range(4) == 0) ? 8'($urandom) : 8'h01;
      push_txn(mbc3_pkg::MODE_WRITE,
               16'(mbc3_pkg::ADDR_RAM_SEL + $urandom_range(16'h1FFF)), 8'h00);
      push_txn(mbc3_pkg::MODE_WRITE,
               16'(mbc3_pkg::ADDR_RAM_SEL + $urandom_range(16'h1FFF)), v);
      if ($urandom_range(1))
        push_txn(mbc3_pkg::MODE_READ,
                 16'(mbc3_pkg::ADDR_RAM_LO + $urandom_range(16'h1FFF)), 8'($urandom));
    end else if (pick < 70) begin
      // Preset a clock register, usually just short of its carry
      k = $urandom_range(4);
      if ($urandom_range(1))
        push_txn(mbc3_pkg::MODE_WRITE, 16'($urandom_range(16'h1FFF)),
                 {4'($urandom), mbc3_pkg::RAM_EN_KEY});
      push_txn(mbc3_pkg::MODE_WRITE,
               16'(mbc3_pkg::ADDR_ROM_SEL + $urandom_range(16'h1FFF)),
               8'(mbc3_pkg::SEL_SEC + k));
      v = ($urandom_range(9) < 7) ? near_limit[k] : 8'($urandom);
      push_txn(mbc3_pkg::MODE_WRITE,
               16'(mbc3_pkg::ADDR_RAM_LO + $urandom_range(16'h1FFF)), v);
      if ($urandom_range(1))
        push_txn(mbc3_pkg::MODE_READ,
                 16'(mbc3_pkg::ADDR_RAM_LO + $urandom_range(16'h1FFF)), 8'($urandom));
    end else if (pick < 88) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (n) push_txn(mbc3_pkg::MODE_TICK, 16'($urandom), 8'($urandom));
    end else begin
      push_txn(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
    end
  endtask

  // Reconfigure while idle, then run one batch of random traffic
  task automatic run_phase(input logic [7:0] mask, input logic [1:0] code,
                           input logic [23:0] tps, input int n_rand,
                           input int s_pct, input int r_pct, input int pressure);
    int start;
    write_cfg(mbc3_pkg::CFG_ROM_BANK_MASK, 24'(mask));
    write_cfg(mbc3_pkg::CFG_RAM_SIZE_CODE, 24'(code));
    write_cfg(mbc3_pkg::CFG_TICKS_PER_SECOND, tps);
    n_settings++;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = n_queued;
    while (n_queued - start < n_rand) queue_random_burst();
    if (pressure != PRESS_NONE) begin
      do next_cycle(); while (bus_txn_q.size() > n_rand / 2);
      if (pressure == PRESS_RX_STALL) begin
        rx_stall_left = 300;
      end else begin
        // Pause the sender until every outstanding read has returned
        send_hold = 1'b1;
        do next_cycle(); while (in_valid || read_results_q.size() != 0);
        repeat (4) next_cycle();
        send_hold = 1'b0;
      end
    end
    drain();
  endtask

  initial begin
    foreach (ram_img[i]) ram_img[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed sequence: mapping corners, RAM guards, clock wrap, halt and day carry
    write_cfg(mbc3_pkg::CFG_ROM_BANK_MASK, 24'h00000F);
    write_cfg(mbc3_pkg::CFG_RAM_SIZE_CODE, 24'd2);
    write_cfg(mbc3_pkg::CFG_TICKS_PER_SECOND, 24'd1);
    n_settings++;
    send_idle_pct = 16;
    recv_idle_pct = 47;
    push_txn(mbc3_pkg::MODE_READ,  16'h0000, 8'h00);
    push_txn(mbc3_pkg::MODE_READ,  16'h7FFF, 8'hFF);
    push_txn(mbc3_pkg::MODE_READ,  16'hA000, 8'h00);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h1FFF, 8'h3A);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h4000, 8'h07);
    push_txn(mbc3_pkg::MODE_WRITE, 16'hBFFF, 8'hA5);
    push_txn(mbc3_pkg::MODE_READ,  16'hBFFF, 8'h00);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h2000, 8'h00);
    push_txn(mbc3_pkg::MODE_READ,  16'h4000, 8'h00);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h3FFF, 8'h10);
    push_txn(mbc3_pkg::MODE_READ,  16'h7FFF, 8'h00);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h5FFF, 8'h05);
    push_txn(mbc3_pkg::MODE_READ,  16'hA000, 8'h00);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h4000, 8'(mbc3_pkg::SEL_SEC));
    push_txn(mbc3_pkg::MODE_WRITE, 16'hA000, 8'hFF);
    push_txn(mbc3_pkg::MODE_TICK,  16'hFFFF, 8'hFF);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h4000, 8'(mbc3_pkg::SEL_DAYH));
    push_txn(mbc3_pkg::MODE_WRITE, 16'hA000, 8'hFF);
    push_txn(mbc3_pkg::MODE_TICK,  16'h0000, 8'h00);
    push_txn(mbc3_pkg::MODE_READ,  16'hA000, 8'h00);
    push_txn(mbc3_pkg::MODE_WRITE, 16'hA000, 8'h01);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h4000, 8'(mbc3_pkg::SEL_DAYL));
    push_txn(mbc3_pkg::MODE_WRITE, 16'hA000, 8'hFF);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h4000, 8'(mbc3_pkg::SEL_HOUR));
    push_txn(mbc3_pkg::MODE_WRITE, 16'hA000, 8'd23);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h4000, 8'(mbc3_pkg::SEL_MIN));
    push_txn(mbc3_pkg::MODE_WRITE, 16'hA000, 8'd59);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h4000, 8'(mbc3_pkg::SEL_SEC));
    push_txn(mbc3_pkg::MODE_WRITE, 16'hA000, 8'd59);
    push_txn(mbc3_pkg::MODE_TICK,  16'h0000, 8'h00);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h6000, 8'h00);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h7FFF, 8'h01);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h4000, 8'(mbc3_pkg::SEL_DAYH));
    push_txn(mbc3_pkg::MODE_READ,  16'hA000, 8'h00);
    push_txn(2'd3,                 16'hA000, 8'h55);
    push_txn(mbc3_pkg::MODE_WRITE, 16'h8000, 8'h0A);
    push_txn(mbc3_pkg::MODE_READ,  16'h9000, 8'h00);
    push_txn(mbc3_pkg::MODE_READ,  16'hC000, 8'h00);
    drain();

    // Random phases across register settings and idling patterns
    run_phase(8'h0F, 2'd1, 24'd2,        280, 16, 47, PRESS_NONE);
    run_phase(8'hFF, 2'd2, 24'd1,        280, 16, 47, PRESS_RX_STALL);
    run_phase(8'h01, 2'd0, 24'd3,        280, 47, 16, PRESS_NONE);
    run_phase(8'h7F, 2'd3, 24'd0,        280, 47, 16, PRESS_TX_PAUSE);
    run_phase(8'hFF, 2'd2, 24'hFFFFFF,   270, 0,  0,  PRESS_RX_STALL);
    run_phase(8'h3F, 2'd1, 24'd5,        270, 0,  0,  PRESS_NONE);
    repeat (6) next_cycle();

    $display("Run covered %0d bus transactions (%0d clock ticks) under %0d register settings,",
             n_accepted, n_ticks, n_settings);
    $display("with %0d read results compared and %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && read_results_q.size() == 0) begin
      $display("[mbc3_bank_mapper_with_rtc] OK");
    end else begin
      $display("[mbc3_bank_mapper_with_rtc] ERROR");
    end
    $finish;
  end

  // Watchdog: reset clearing pass plus all traffic fits well inside this
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", read_results_q.size());
    $display("[mbc3_bank_mapper_with_rtc] ERROR");
    $finish;
  end

endmodule
